// ===== rtl/radix_digit_converter_unit_macros.svh =====
// Assertion macros used by the checker of the radix digit converter.
`ifndef RADIX_DIGIT_CONVERTER_UNIT_MACROS_SVH
`define RADIX_DIGIT_CONVERTER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RDC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rdc assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RDC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rdc assertion failed");

`endif

// ===== rtl/rdc_pkg.sv =====
package rdc_pkg;

    // Field widths
    localparam int VALUE_W  = 31;
    localparam int RADIX_W  = 6;
    localparam int DIGIT_W  = 6;
    localparam int CHAR_W   = 8;
    localparam int STATUS_W = 2;

    // Digit buffer sizing
    localparam int MAX_DIGITS = 32;
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W      = $clog2(MAX_DIGITS);
    localparam int BITCNT_W   = $clog2(VALUE_W);

    // Stream packing, padded to whole bytes; status travels on tuser
    localparam int S_FIELDS_W = VALUE_W + RADIX_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = DIGIT_W + CHAR_W + 1;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // Radix constants
    localparam logic [RADIX_W-1:0] MIN_RADIX = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] HEX_RADIX = RADIX_W'(16);

    // ASCII constants
    localparam logic [CHAR_W-1:0] CHAR_DIGIT0 = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_ALPHA0 = 8'h41;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DIGIT    = 2'd0,
        STATUS_ZERO     = 2'd1,
        STATUS_BAD_BASE = 2'd2
    } status_t;

    // ASCII character of a digit; 0 above hex range
    function automatic logic [CHAR_W-1:0] char_of(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] dw;
        dw = CHAR_W'(d);
        if (d <= DIGIT_W'(9)) begin
            return CHAR_DIGIT0 + dw;
        end else if (d <= DIGIT_W'(15)) begin
            return CHAR_ALPHA0 + (dw - CHAR_W'(10));
        end else begin
            return '0;
        end
    endfunction

endpackage

// ===== rtl/radix_digit_converter_unit.sv =====
// Converts a 31-bit magnitude to its digits in a base of 2 to 63 and streams
// one transaction per digit, most significant first, with the ASCII character,
// a group-space flag (groups of 2 for base 16, of 4 otherwise) and tlast on
// the final digit; tuser carries the status. A base below 2 yields one
// transaction with status "invalid base"; a value of zero yields one with
// status "zero". Each digit comes from
// a restoring division that shares one 7-bit subtract/compare, shifting one
// dividend bit per ST_DIV step, then ST_STORE stores the remainder; each digit
// is then output through ST_FETCH (the registered digit buffer read), ST_EMIT
// (the output register) and ST_WAIT, where stalls on m_tready hold it.
// Error and zero results are registered at acceptance, with no division.
// s_tready is high only while no conversion is in progress and no result
// waits.
module radix_digit_converter_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [30:0] value, [36:31] radix, rest zero
    input  logic [rdc_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [5:0] digit, [13:6] char_code, [14] space_before, rest zero
    output logic [rdc_pkg::M_TDATA_W-1:0] m_tdata,
    // [1:0] status
    output logic [rdc_pkg::STATUS_W-1:0]  m_tuser,
    output logic                          m_tlast
);
    import rdc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_STORE,
        ST_FETCH,
        ST_EMIT,
        ST_WAIT
    } state_t;

    state_t               state_reg;
    logic [VALUE_W-1:0]   q_reg;
    logic [DIGIT_W-1:0]   rem_reg;
    logic [RADIX_W-1:0]   radix_reg;
    logic [BITCNT_W-1:0]  bit_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [IDX_W-1:0]     rd_ptr_reg;
    logic [IDX_W-1:0]     pos_reg;
    logic [DIGIT_W-1:0]   rd_data_reg;

    logic                 m_tvalid_reg;
    logic                 m_tlast_reg;
    logic [DIGIT_W-1:0]   digit_reg;
    logic [CHAR_W-1:0]    char_reg;
    logic                 space_reg;
    status_t              status_reg;

    // Digit buffer, remainders least significant first
    logic [DIGIT_W-1:0]   buf_mem [MAX_DIGITS];

    // Input fields
    logic [VALUE_W-1:0]   in_value;
    logic [RADIX_W-1:0]   in_radix;
    logic                 s_xfer;

    assign in_value = s_tdata[VALUE_W-1:0];
    assign in_radix = s_tdata[S_FIELDS_W-1:VALUE_W];
    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;

    // Shared divide step: shift one dividend bit into the remainder, try subtract
    logic [DIGIT_W:0]     rem_shift;
    logic [DIGIT_W:0]     rem_sub;
    logic                 rem_ge;
    logic [DIGIT_W-1:0]   rem_step;

    always_comb begin
        rem_shift = {rem_reg, q_reg[VALUE_W-1]};
        rem_sub   = rem_shift - {1'b0, radix_reg};
        rem_ge    = (rem_shift >= {1'b0, radix_reg});
        rem_step  = rem_ge ? rem_sub[DIGIT_W-1:0] : rem_shift[DIGIT_W-1:0];
    end

    // Store bookkeeping
    logic                 buf_has_room;
    logic [CNT_W-1:0]     cnt_inc;

    always_comb begin
        buf_has_room = (cnt_reg < CNT_W'(MAX_DIGITS));
        cnt_inc      = buf_has_room ? cnt_reg + CNT_W'(1) : cnt_reg;
    end

    // Group-space flag for the digit at pos_reg
    logic                 space_calc;

    always_comb begin
        if (radix_reg == HEX_RADIX) begin
            space_calc = (pos_reg != '0) && (pos_reg[0] == 1'b0);
        end else begin
            space_calc = (pos_reg != '0) && (pos_reg[1:0] == 2'b00);
        end
    end

    // Digit buffer write and registered read
    always_ff @(posedge aclk) begin
        if (state_reg == ST_STORE && buf_has_room) begin
            buf_mem[cnt_reg[IDX_W-1:0]] <= rem_reg;
        end
        if (state_reg == ST_FETCH) begin
            rd_data_reg <= buf_mem[rd_ptr_reg];
        end
    end

    // Sequencer, datapath registers and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_xfer) begin
                        radix_reg <= in_radix;
                        q_reg     <= in_value;
                        rem_reg   <= '0;
                        bit_reg   <= '0;
                        pos_reg   <= '0;
                        if (in_radix < MIN_RADIX) begin
                            digit_reg    <= '0;
                            char_reg     <= '0;
                            space_reg    <= 1'b0;
                            status_reg   <= STATUS_BAD_BASE;
                            m_tlast_reg  <= 1'b1;
                            m_tvalid_reg <= 1'b1;
                            state_reg    <= ST_WAIT;
                        end else if (in_value == '0) begin
                            cnt_reg      <= '0;
                            digit_reg    <= '0;
                            char_reg     <= '0;
                            space_reg    <= 1'b0;
                            status_reg   <= STATUS_ZERO;
                            m_tlast_reg  <= 1'b1;
                            m_tvalid_reg <= 1'b1;
                            state_reg    <= ST_WAIT;
                        end else begin
                            cnt_reg   <= '0;
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    q_reg   <= {q_reg[VALUE_W-2:0], rem_ge};
                    rem_reg <= rem_step;
                    if (bit_reg == BITCNT_W'(VALUE_W - 1)) begin
                        state_reg <= ST_STORE;
                    end else begin
                        bit_reg <= bit_reg + BITCNT_W'(1);
                    end
                end
                ST_STORE: begin
                    // rem_reg holds the finished remainder, q_reg the quotient
                    cnt_reg <= cnt_inc;
                    rem_reg <= '0;
                    bit_reg <= '0;
                    if (q_reg == '0) begin
                        rd_ptr_reg <= IDX_W'(cnt_inc - CNT_W'(1));
                        state_reg  <= ST_FETCH;
                    end else begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_FETCH: begin
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    digit_reg    <= rd_data_reg;
                    char_reg     <= char_of(rd_data_reg);
                    space_reg    <= space_calc;
                    status_reg   <= STATUS_DIGIT;
                    m_tlast_reg  <= (rd_ptr_reg == '0);
                    m_tvalid_reg <= 1'b1;
                    state_reg    <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (m_tready) begin
                        m_tvalid_reg <= 1'b0;
                        if (m_tlast_reg) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            rd_ptr_reg <= rd_ptr_reg - IDX_W'(1);
                            pos_reg    <= pos_reg + IDX_W'(1);
                            state_reg  <= ST_FETCH;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Output packing
    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = M_TDATA_W'({space_reg, char_reg, digit_reg});
    assign m_tuser  = status_reg;

endmodule

// ===== rtl/rdc_checker.sv =====
`include "radix_digit_converter_unit_macros.svh"

module rdc_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [rdc_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [rdc_pkg::STATUS_W-1:0]  m_tuser,
    input logic                          m_tlast
);
    import rdc_pkg::*;

    logic [DIGIT_W-1:0]  chk_digit;
    logic [CHAR_W-1:0]   chk_char;
    logic [STATUS_W-1:0] chk_status;

    assign chk_digit  = m_tdata[DIGIT_W-1:0];
    assign chk_char   = m_tdata[DIGIT_W+CHAR_W-1:DIGIT_W];
    assign chk_status = m_tuser;

    // No new input while a result is pending
    `RDC_ASSERT_IMPL(a_no_ready_with_result, aclk, aresetn, m_tvalid, !s_tready)

    // A conversion occupies the block past the accepting edge
    `RDC_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // Zero and invalid-base results stand alone
    `RDC_ASSERT_IMPL(a_status_single, aclk, aresetn, m_tvalid && (chk_status != STATUS_DIGIT), m_tlast)

    // Digits above hex range carry no character
    `RDC_ASSERT_IMPL(a_char_range, aclk, aresetn, m_tvalid && (chk_digit > DIGIT_W'(15)), chk_char == '0)

    // A stalled result holds
    `RDC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

endmodule

bind radix_digit_converter_unit rdc_checker u_rdc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== verif/tb_radix_digit_converter_unit.sv =====
module tb_radix_digit_converter_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import rdc_pkg::*;

    localparam int QUIET_LIMIT = 6000;   // cycles with no transaction on either side
    localparam int TAIL_CYCLES = 40;

    // One expected digit transaction
    typedef struct {
        logic [DIGIT_W-1:0] digit;
        logic [CHAR_W-1:0]  char_code;
        logic               space_before;
        status_t            status;
        logic               last;
    } digit_result_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [STATUS_W-1:0]    m_tuser;
    logic                   m_tlast;

    digit_result_t          digits_pending[$];
    int                     send_idle_pct;
    int                     recv_idle_pct;
    int                     err_count;
    int                     quiet_cycles;
    int                     n_items;
    int                     n_digits;
    int                     n_bad_base;
    int                     n_zero;

    radix_digit_converter_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // 10 ns clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // ASCII of one digit: '0'..'9', 'A'..'F', nothing above 15
    function automatic logic [CHAR_W-1:0] ascii_of_digit(input logic [DIGIT_W-1:0] d);
        if (d < 6'd10) begin
            return 8'h30 + {2'b00, d};
        end else if (d < 6'd16) begin
            return 8'h41 + {2'b00, d} - 8'd10;
        end
        return 8'h00;
    endfunction

    // Expected digit stream for one conversion, most significant first
    task automatic predict_conversion(input logic [VALUE_W-1:0] value,
                                      input logic [RADIX_W-1:0] radix);
        logic [DIGIT_W-1:0] remainders[MAX_DIGITS];
        int unsigned        v;
        int unsigned        n;
        int unsigned        grp;
        digit_result_t      r;
        v = value;
        n = 0;
        grp = (radix == HEX_RADIX) ? 2 : 4;
        r.digit = '0;
        r.char_code = '0;
        r.space_before = 1'b0;
        r.last = 1'b1;
        if (radix < MIN_RADIX) begin
            r.status = STATUS_BAD_BASE;
            digits_pending.push_back(r);
            n_bad_base++;
        end else if (v == 0) begin
            r.status = STATUS_ZERO;
            digits_pending.push_back(r);
            n_zero++;
        end else begin
            // remainders least significant first; keep the low MAX_DIGITS
            while (v != 0) begin
                if (n < MAX_DIGITS) begin
                    remainders[n] = DIGIT_W'(v % radix);
                    n++;
                end
                v = v / radix;
            end
            for (int i = 0; i < n; i++) begin
                r.digit = remainders[n - 1 - i];
                r.char_code = ascii_of_digit(r.digit);
                r.space_before = (i != 0) && ((i % grp) == 0);
                r.status = STATUS_DIGIT;
                r.last = (i + 1 == n);
                digits_pending.push_back(r);
            end
            n_digits += n;
        end
    endtask

    // Present one item and hold it until the block takes it
    task automatic send_number(input logic [VALUE_W-1:0] value,
                               input logic [RADIX_W-1:0] radix);
        logic taken;
        taken = 1'b0;
        while (!taken) begin
            @(negedge aclk);
            if ($urandom_range(99) < send_idle_pct) begin
                s_tvalid <= 1'b0;
                s_tdata  <= '0;
            end else begin
                s_tvalid <= 1'b1;
                s_tdata  <= S_TDATA_W'({radix, value});
                @(posedge aclk);
                while (!s_tready) @(posedge aclk);
                predict_conversion(value, radix);
                n_items++;
                taken = 1'b1;
            end
        end
    endtask

    // Drop the request line once the stimulus of a phase is done
    task automatic release_input();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
    endtask

    task automatic drain_results();
        while (digits_pending.size() != 0) @(posedge aclk);
    endtask

    task automatic test_invalid_base();
        send_number(31'd5, 6'd0);
        send_number(31'd5, 6'd1);
        send_number(31'd0, 6'd0);
        send_number(31'h7FFF_FFFF, 6'd1);
    endtask

    task automatic test_zero_value();
        send_number(31'd0, 6'd2);
        send_number(31'd0, HEX_RADIX);
        send_number(31'd0, 6'd63);
    endtask

    task automatic test_extremes();
        // longest conversion, alternating bit patterns, widest bases
        send_number(31'h7FFF_FFFF, MIN_RADIX);
        send_number(31'h2AAA_AAAA, MIN_RADIX);
        send_number(31'h5555_5555, MIN_RADIX);
        send_number(31'd1, MIN_RADIX);
        send_number(31'h7FFF_FFFF, 6'd10);
        send_number(31'h7FFF_FFFF, HEX_RADIX);
        send_number(31'h7FFF_FFFF, 6'd36);
        send_number(31'h7FFF_FFFF, 6'd63);
        send_number(31'd62, 6'd63);
        send_number(31'd3968, 6'd63);
        send_number(31'd63, 6'd63);
    endtask

    task automatic test_grouping_and_letters();
        // hex letters, hex pairs, groups of four elsewhere
        send_number(31'h7EDC_BA98, HEX_RADIX);
        send_number(31'h1234_5678, HEX_RADIX);
        send_number(31'd15, HEX_RADIX);
        send_number(31'd255, HEX_RADIX);
        send_number(31'd256, HEX_RADIX);
        send_number(31'd1234567890, 6'd10);
        send_number(31'd4095, 6'd8);
    endtask

    // Random conversions with random magnitude length and base
    task automatic test_random_conversions(input int count);
        logic [VALUE_W-1:0] value;
        logic [RADIX_W-1:0] radix;
        int unsigned        len;
        for (int k = 0; k < count; k++) begin
            len = $urandom_range(31, 0);
            value = VALUE_W'($urandom & ((32'h1 << len) - 1));
            if ($urandom_range(9) == 0) begin
                value = VALUE_W'((32'h1 << len) - 1);
            end
            if ($urandom_range(9) == 0) begin
                radix = RADIX_W'($urandom_range(1, 0));
            end else begin
                radix = RADIX_W'($urandom_range(63, 2));
            end
            send_number(value, radix);
        end
    endtask

    // Result side stalls at random
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Compare each digit transaction with the oldest expectation
    always @(posedge aclk) begin
        digit_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (digits_pending.size() == 0) begin
                $error("unexpected result: tdata=%h tuser=%h tlast=%b",
                       m_tdata, m_tuser, m_tlast);
                err_count++;
            end else begin
                want = digits_pending.pop_front();
                if (m_tdata[5:0] !== want.digit) begin
                    $error("digit: expected %0d, got %0d", want.digit, m_tdata[5:0]);
                    err_count++;
                end
                if (m_tdata[13:6] !== want.char_code) begin
                    $error("char_code: expected %h, got %h", want.char_code, m_tdata[13:6]);
                    err_count++;
                end
                if (m_tdata[14] !== want.space_before) begin
                    $error("space_before: expected %b, got %b", want.space_before, m_tdata[14]);
                    err_count++;
                end
                if (m_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    err_count++;
                end
                if (m_tlast !== want.last) begin
                    $error("last: expected %b, got %b", want.last, m_tlast);
                    err_count++;
                end
            end
        end
    end

    // Watchdog: give up after a long stretch with no transaction
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: %0d results still expected", digits_pending.size());
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        send_idle_pct = 7;
        recv_idle_pct = 62;
        err_count = 0;
        quiet_cycles = 0;
        n_items = 0;
        n_digits = 0;
        n_bad_base = 0;
        n_zero = 0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // slow receiver
        test_invalid_base();
        test_zero_value();
        test_extremes();
        test_grouping_and_letters();
        test_random_conversions(35);
        release_input();
        drain_results();

        // slow sender
        send_idle_pct = 62;
        recv_idle_pct = 7;
        test_random_conversions(35);
        release_input();
        drain_results();

        // full rate both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_conversions(35);
        release_input();
        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d conversions: %0d digits, %0d zero values, %0d bad bases",
                 n_items, n_digits, n_zero, n_bad_base);
        $display("idle mixes: slow receiver, slow sender, no stalls; %0d mismatches",
                 err_count);
        if (err_count == 0 && digits_pending.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/rdc_pkg.sv
rtl/radix_digit_converter_unit.sv
rtl/rdc_checker.sv
verif/tb_radix_digit_converter_unit.sv
